// ===== rtl/core/jrds_pkg.sv =====
//------------------------------------------------------------------------------
// jrds_pkg
// Shared widths and types for the requantize / dry-select core.
//------------------------------------------------------------------------------
package jrds_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
	localparam int COUNT_BITS  = 24;
	localparam int Q_BITS      = 8;
	localparam int COEF_BITS   = 12;
	localparam int MAG_BITS    = 19;   // |coef * fq| <= 2048*255
	localparam int RES_BITS    = 20;
	localparam int NCELL       = MAG_BITS;
	localparam int STEP_BITS   = $clog2(NCELL + 1);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_COEF = 1'b1;

	// divider cell state handed down the chain each cycle that the chain is enabled
	typedef struct packed {
		logic [MAG_BITS-1:0] rem;  // partial remainder / dividend shift
		logic [MAG_BITS-1:0] quo;
	} div_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/core/jpeg_requantize_dry_select_core.sv =====
//------------------------------------------------------------------------------
// jpeg_requantize_dry_select_core
// Requantizes JPEG coefficients to a reduced table and flags dry ones.
//------------------------------------------------------------------------------
// One word at a time. A load word is taken without leaving the idle state, so
// loads can follow back to back. A coefficient word passes through the table
// read, the row of restoring-division cells (one quotient bit per cell, with
// the multiply in front of the first cell), and the output register, which
// also takes the residue/threshold test. A new input is taken in the cycle
// after the result has been handed off; while the output is stalled, the
// result is held and the core stays busy. The tables come up undefined and
// must be loaded before use.
module jpeg_requantize_dry_select_core
	import jrds_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [6:0]                  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [5:0]                  table_index,
	input  logic [7:0]                  full_quant,
	input  logic [7:0]                  reduced_quant,
	input  logic signed [11:0]          coefficient,
	input  logic                        first_coefficient,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [19:0]          requantized,
	output logic                        parity,
	output logic                        dry,
	output logic [23:0]                 dry_total
);

	state_t               state_q, state_d;
	logic [STEP_BITS-1:0] step_q;
	logic [6:0]           thr_q;
	logic [IDX_BITS-1:0]  pos_q;
	logic [IDX_BITS-1:0]  rd_pos;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                 acc;
	logic                 sign_q;
	logic signed [COEF_BITS-1:0] coef_q;
	logic                 mul_q;
	logic [MAG_BITS-1:0]  absx_q;
	logic [Q_BITS-1:0]    fq_rd, qr_rd, qr_eff;
	logic                 ram_we;
	div_word_t            div_in, div_out;
	logic                 div_en;

	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;
	assign ram_we   = acc && (opcode == OP_LOAD);

	// a restart reads entry 0 in the same cycle the position clears
	assign rd_pos = (acc && opcode == OP_COEF && first_coefficient) ? '0 : pos_q;

	// quantizer tables
	jrds_ram #(.WIDTH(Q_BITS), .DEPTH(TABLE_DEPTH)) u_full (
		.clk(clk), .we(ram_we), .waddr(table_index[IDX_BITS-1:0]),
		.wdata(full_quant), .raddr(rd_pos), .rdata(fq_rd)
	);
	jrds_ram #(.WIDTH(Q_BITS), .DEPTH(TABLE_DEPTH)) u_red (
		.clk(clk), .we(ram_we), .waddr(table_index[IDX_BITS-1:0]),
		.wdata(reduced_quant), .raddr(rd_pos), .rdata(qr_rd)
	);

	assign qr_eff = (qr_rd == '0) ? Q_BITS'(1) : qr_rd;

	// dividend: |x| + qr/2, captured after multiply
	logic signed [COEF_BITS+Q_BITS:0] prod;
	logic [MAG_BITS-1:0] absx;
	logic [MAG_BITS-1:0] dvd;
	assign prod = coef_q * $signed({1'b0, fq_rd});
	assign absx = prod[COEF_BITS+Q_BITS] ? MAG_BITS'(-prod) : MAG_BITS'(prod);
	assign dvd  = absx + {{(MAG_BITS+1-Q_BITS){1'b0}}, qr_eff[Q_BITS-1:1]};

	always_comb begin
		div_in.rem = '0;
		div_in.quo = dvd;
	end
	assign div_en = (state_q == ST_READ) || (state_q == ST_DIV);

	jrds_div_chain u_chain (
		.clk(clk), .en(div_en), .divisor(qr_eff), .din(div_in), .dout(div_out)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (acc && opcode == OP_COEF) state_d = ST_READ;
			ST_READ: state_d = ST_DIV;
			ST_DIV:  if (step_q == STEP_BITS'(NCELL)) state_d = ST_OUT;
			ST_OUT:  if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// residue and dry test off the chain output
	logic [MAG_BITS-1:0] rmag;
	logic [MAG_BITS+Q_BITS-1:0] rq;
	logic [MAG_BITS+Q_BITS:0] dd;
	logic [MAG_BITS+Q_BITS+8:0] lhs, rhs;
	logic [6:0] thr_s;
	logic nz, is_dry;
	always_comb begin
		rmag  = div_out.quo;
		rq    = rmag * qr_eff;
		dd    = {1'b0, rq} - {{(Q_BITS+1){1'b0}}, absx_q};
		if (dd[MAG_BITS+Q_BITS]) dd = -dd;
		thr_s = (thr_q > 7'd100) ? 7'd100 : thr_q;
		lhs   = (MAG_BITS+Q_BITS+9)'(dd) * (MAG_BITS+Q_BITS+9)'(200);
		rhs   = (MAG_BITS+Q_BITS+9)'(7'd100 - thr_s) * (MAG_BITS+Q_BITS+9)'(qr_eff);
		nz    = mul_q && (rmag != '0);
		is_dry = nz && (lhs > rhs);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			thr_q   <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) thr_q <= cfg_wdata;
			if (acc && opcode == OP_COEF && first_coefficient) begin
				pos_q <= '0;
				cnt_q <= '0;
			end
			if (state_q == ST_READ) step_q <= STEP_BITS'(1);
			else if (state_q == ST_DIV) step_q <= step_q + 1'b1;
			if (state_q == ST_DIV && step_q == STEP_BITS'(NCELL)) begin
				out_valid <= 1'b1;
				pos_q <= pos_q + 1'b1;
				if (is_dry && cnt_q != '1) cnt_q <= cnt_q + 1'b1;
			end else if (state_q == ST_OUT && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload
	logic [COUNT_BITS-1:0] cnt_nx;
	assign cnt_nx = (is_dry && cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
	always_ff @(posedge clk) begin
		if (acc) coef_q <= coefficient;
		if (state_q == ST_READ) begin
			sign_q <= prod[COEF_BITS+Q_BITS];
			mul_q  <= (absx != '0);
			absx_q <= absx;
		end
		if (state_q == ST_DIV && step_q == STEP_BITS'(NCELL)) begin
			requantized <= nz ? (sign_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag}))
			                  : '0;
			parity      <= nz & rmag[0];
			dry         <= is_dry;
			dry_total   <= 24'(cnt_nx);
		end
	end

endmodule

// ===== rtl/core/jrds_ram.sv =====
//------------------------------------------------------------------------------
// jrds_ram
// Generic single-port-write, registered-read RAM.
//------------------------------------------------------------------------------
module jrds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/jrds_div_cell.sv =====
//------------------------------------------------------------------------------
// jrds_div_cell
// One restoring-division cell: takes one dividend bit, emits one quotient bit.
//------------------------------------------------------------------------------
module jrds_div_cell
	import jrds_pkg::*;
(
	input  logic                clk,
	input  logic                en,
	input  logic [Q_BITS-1:0]   divisor,
	input  div_word_t           din,
	output div_word_t           dout
);

	logic [MAG_BITS:0]   trial;
	logic [MAG_BITS-1:0] rem_sh;
	div_word_t           nxt;

	// shift in the next dividend bit (taken from the top of quo) and try subtract
	always_comb begin
		rem_sh = {din.rem[MAG_BITS-2:0], din.quo[MAG_BITS-1]};
		trial  = {1'b0, rem_sh} - {{(MAG_BITS+1-Q_BITS){1'b0}}, divisor};
		nxt.quo = {din.quo[MAG_BITS-2:0], ~trial[MAG_BITS]};
		nxt.rem = trial[MAG_BITS] ? rem_sh : trial[MAG_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

// ===== rtl/core/jrds_div_chain.sv =====
//------------------------------------------------------------------------------
// jrds_div_chain
// Row of division cells; the word moves one cell per cycle while en is high.
//------------------------------------------------------------------------------
module jrds_div_chain
	import jrds_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [Q_BITS-1:0] divisor,
	input  div_word_t         din,
	output div_word_t         dout
);

	div_word_t link [NCELL+1];

	assign link[0] = din;

	// cell row
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		jrds_div_cell u_cell (
			.clk     (clk),
			.en      (en),
			.divisor (divisor),
			.din     (link[i]),
			.dout    (link[i+1])
		);
	end

	assign dout = link[NCELL];

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the requantize / dry-select core. Tables are loaded
// by load words, then coefficient words are sent under random gaps and output
// stalls; a local model predicts each result and a monitor compares them.
//------------------------------------------------------------------------------
module tb_top
	import jrds_pkg::*;
;

	typedef struct {
		logic signed [19:0] requant;
		logic               par;
		logic               dry_f;
		logic [23:0]        dry_cnt;
	} requant_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = OP_LOAD;
	logic [5:0] table_index = '0;
	logic [7:0] full_quant = 8'd1;
	logic [7:0] reduced_quant = 8'd1;
	logic signed [11:0] coefficient = '0;
	logic first_coefficient = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [19:0] requantized;
	logic parity;
	logic dry;
	logic [23:0] dry_total;

	// model state
	logic [7:0]  m_fq [TABLE_DEPTH];
	logic [7:0]  m_qr [TABLE_DEPTH];
	logic [5:0]  m_pos;
	logic [23:0] m_dry_cnt;
	logic [6:0]  m_thr;

	requant_res_t pending_q[$];
	int errors = 0;
	int n_coef = 0, n_dry = 0, n_load = 0;
	int idle_cycles = 0;
	bit stall_en = 1'b1;

	jpeg_requantize_dry_select_core uut (.*);

	always #5 clk = ~clk;

	// Random gap length: mostly short, sometimes long
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Predict the result of one coefficient word
	function automatic requant_res_t predict_requant(logic signed [11:0] c, logic first);
		requant_res_t res;
		longint x, mag, r, d, qr, thr;
		if (first) begin
			m_pos = '0;
			m_dry_cnt = '0;
		end
		qr = (m_qr[m_pos] == 0) ? 1 : m_qr[m_pos];
		x = longint'(c) * longint'(m_fq[m_pos]);
		r = 0;
		res.par = 1'b0;
		res.dry_f = 1'b0;
		if (x != 0) begin
			mag = (x < 0) ? -x : x;
			r = (mag + (qr >> 1)) / qr;
			d = mag - r * qr;
			if (d < 0) d = -d;
			if (x < 0) r = -r;
			res.par = r[0];
			thr = (m_thr > 100) ? 100 : m_thr;
			if (r != 0 && 200 * d > (100 - thr) * qr) begin
				res.dry_f = 1'b1;
				if (m_dry_cnt != 24'hFFFFFF) m_dry_cnt++;
			end
		end
		m_pos = m_pos + 1'b1;
		res.requant = r[19:0];
		res.dry_cnt = m_dry_cnt;
		return res;
	endfunction

	// Send one word and update the model on acceptance; valid stays up
	// after acceptance only when the next word follows at once
	task automatic send_word(logic op, logic [5:0] idx, logic [7:0] fq, logic [7:0] qr,
			logic signed [11:0] c, logic first);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		table_index <= idx;
		full_quant <= fq;
		reduced_quant <= qr;
		coefficient <= c;
		first_coefficient <= first;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (op == OP_LOAD) begin
			m_fq[idx] = fq;
			m_qr[idx] = qr;
			n_load++;
		end else begin
			pending_q.push_back(predict_requant(c, first));
			n_coef++;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_threshold(logic [6:0] t);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_thr = t;
	endtask

	function automatic logic signed [11:0] rand_coef();
		int p;
		p = $urandom_range(0, 9);
		if (p < 6) return 12'($signed($urandom_range(0, 40)) - 20);
		return 12'($urandom);
	endfunction

	task automatic load_tables(bit extreme);
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_word(OP_LOAD, i[5:0],
				extreme ? (i[0] ? 8'd255 : 8'd1) : 8'($urandom_range(1, 255)),
				extreme ? (i[1] ? 8'd255 : 8'd1) : 8'($urandom_range(1, 255)), '0, 1'b0);
	endtask

	// Directed: extreme coefficients and quantizers, zero product
	task automatic test_directed();
		logic signed [11:0] vals [8];
		vals = '{12'sh800, 12'sh7FF, 12'sh000, 12'sh001, 12'shFFF, 12'sh555, 12'shAAA, 12'sh010};
		load_tables(1'b1);
		for (int i = 0; i < 24; i++)
			send_word(OP_COEF, 6'($urandom), 8'($urandom), 8'($urandom), vals[i % 8], i == 0);
	endtask

	// Random coefficient streams, with occasional reloads and restarts
	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 39) == 0)
				send_word(OP_LOAD, 6'($urandom), 8'($urandom_range(1, 255)),
					8'($urandom_range(1, 255)), 12'($urandom), 1'($urandom));
			else
				send_word(OP_COEF, 6'($urandom), 8'($urandom), 8'($urandom), rand_coef(),
					$urandom_range(0, 49) == 0);
		end
	endtask

	// Threshold sweep including the extremes and above-range values
	task automatic test_thresholds();
		logic [6:0] t [5];
		t = '{7'd100, 7'd127, 7'd50, 7'd1, 7'd0};
		foreach (t[k]) begin
			set_threshold(t[k]);
			test_random(200);
		end
	endtask

	// Output stall pattern
	always @(posedge clk) begin
		int s;
		s = gap_len();
		if (stall_en && s > 0 && $urandom_range(0, 2) == 0) out_stall <= 1'b1;
		else out_stall <= 1'b0;
	end

	// Result checker
	always @(posedge clk) begin
		requant_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word: r=%0d", requantized);
			end else begin
				e = pending_q.pop_front();
				if (e.dry_f) n_dry++;
				if (requantized !== e.requant || parity !== e.par || dry !== e.dry_f ||
						dry_total !== e.dry_cnt) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp r=%0d p=%0b d=%0b t=%0d got r=%0d p=%0b d=%0b t=%0d",
							e.requant, e.par, e.dry_f, e.dry_cnt,
							requantized, parity, dry, dry_total);
				end
			end
		end
	end

	// Watchdog on accept-free cycles
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		m_pos = '0;
		m_dry_cnt = '0;
		m_thr = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_threshold(7'd0);
		test_directed();
		load_tables(1'b0);
		test_thresholds();
		// hold off until the pipe is empty, then run without output stall
		drain();
		stall_en = 1'b0;
		test_random(150);
		stall_en = 1'b1;
		drain();
		$display("covered %0d coefficient words (%0d dry) and %0d table loads",
			n_coef, n_dry, n_load);
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/jrds_pkg.sv
rtl/core/jrds_ram.sv
rtl/core/jrds_div_cell.sv
rtl/core/jrds_div_chain.sv
rtl/core/jpeg_requantize_dry_select_core.sv
bench/tb_top.sv
